// File: hw/rtl/complex_arithmetic_unit_core_defines.svh
// Assertion macros used by the port-level checker.
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define CAU_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define CAU_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);
`endif

// File: hw/rtl/cau_pkg.sv
// Package with the word types and constants of the complex arithmetic unit.
package cau_pkg;
	localparam int DataWidth = 16;
	localparam int FracBits = 8;
	localparam int QuoWidth = DataWidth + 2 + FracBits;

	typedef enum logic [2:0] {
		OP_NEG = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2,
		OP_DIV = 3'd3, OP_INC = 3'd4, OP_SCALE = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_SAT = 2'd1, ST_DIV0 = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic signed [DataWidth-1:0] a_re;
		logic signed [DataWidth-1:0] a_im;
		logic signed [DataWidth-1:0] b_re;
		logic signed [DataWidth-1:0] b_im;
		logic signed [DataWidth-1:0] scale_factor;
	} req_t;

	typedef struct packed {
		logic signed [DataWidth-1:0] res_re;
		logic signed [DataWidth-1:0] res_im;
		logic [1:0] status;
	} rsp_t;
endpackage

// File: hw/rtl/cau_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating magnitude.
module cau_div (
	input logic clk,
	input logic en,
	input logic [2*cau_pkg::DataWidth:0] num,
	input logic [2*cau_pkg::DataWidth:0] den,
	output logic [cau_pkg::QuoWidth-1:0] quo
);
	import cau_pkg::*;
	localparam int NW = 2*DataWidth + 1;
	localparam int NB = QuoWidth;
	localparam int RW = NW + 1;
	localparam int HI = NB - FracBits;

	logic [RW-1:0] rem_q [NB+1];
	logic [NW-1:0] den_q [NB+1];
	logic [NW-1:0] num_q [NB+1];
	logic [NB-1:0] quo_q [NB+1];
	logic ovf_q [NB+1];

	// The high numerator bits seed the remainder; a quotient too wide for NB bits saturates.
	always_comb begin
		rem_q[0] = RW'(num >> HI);
		ovf_q[0] = (num >> HI) >= den;
		den_q[0] = den;
		num_q[0] = num;
		quo_q[0] = '0;
	end

	for (genvar i = 0; i < NB; i++) begin : g_st
		localparam int SH = NB - 1 - i;
		logic [RW-1:0] rem_n;
		logic bit_n;
		logic [RW-1:0] nb;
		if (SH >= FracBits) begin : g_nb
			assign nb = {{(RW-1){1'b0}}, num_q[i][SH - FracBits]};
		end else begin : g_nz
			assign nb = '0;
		end
		always_comb begin
			rem_n = {rem_q[i][RW-2:0], 1'b0} | nb;
			bit_n = rem_n >= {1'b0, den_q[i]};
			if (bit_n)
				rem_n = rem_n - {1'b0, den_q[i]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i+1] <= rem_n;
				den_q[i+1] <= den_q[i];
				num_q[i+1] <= num_q[i];
				quo_q[i+1] <= {quo_q[i][NB-2:0], bit_n};
				ovf_q[i+1] <= ovf_q[i];
			end
		end
	end

	assign quo = ovf_q[NB] ? '1 : quo_q[NB];
endmodule

// File: hw/rtl/complex_arithmetic_unit_core.sv
// Top level of the complex arithmetic unit: operand decode, products, divide, saturation.
// Usage: one request word on req (valid/ready) yields one response word on rsp.
// Opcodes: negate, subtract, multiply, divide, increment by (1+1i), scale b by a
// real factor. Operands and results are signed Q8.8; results saturate with status 1,
// a zero divisor gives a zero result with status 2.
// Depth: every word passes 31 register stages whatever the opcode (request register,
// three arithmetic stages, 26 divider stages, output register), and it is offered on rsp
// from the output register; the divider, one quotient bit per stage, sets that depth.
// Throughput: one word per cycle unless the receiver stalls. The whole pipeline advances
// together when the output stage is empty or being taken, so a stalled receiver holds
// every word in place and the request channel stalls too; nothing is lost or repeated.
// Reset clears all valid bits; no word is in flight afterward.
module complex_arithmetic_unit_core (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input cau_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output cau_pkg::rsp_t rsp
);
	import cau_pkg::*;
	localparam int W = DataWidth;
	localparam int PW = 2*W;
	localparam int SW = 2*W + 1;
	localparam int DL = QuoWidth;
	localparam int NST = 5 + DL;

	logic adv;
	logic [NST-1:0] vld_q;
	assign adv = !vld_q[NST-1] || rsp_ready;
	assign req_ready = adv;
	assign rsp_valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], req_valid};
		end
	end

	// Stage 1: register request.
	req_t r_s1;
	always_ff @(posedge clk) if (adv) r_s1 <= req;

	// Stage 2: products, simple results.
	logic signed [PW-1:0] p_rr_s2, p_ii_s2, p_ir_s2, p_ri_s2, p_sr_s2, p_si_s2;
	logic signed [SW-1:0] s_re_s2, s_im_s2;
	logic [2:0] op_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2 <= r_s1.req_type;
			p_rr_s2 <= r_s1.a_re * r_s1.b_re;
			p_ii_s2 <= r_s1.a_im * r_s1.b_im;
			p_ir_s2 <= r_s1.a_im * r_s1.b_re;
			p_ri_s2 <= r_s1.a_re * r_s1.b_im;
			p_sr_s2 <= r_s1.scale_factor * r_s1.b_re;
			p_si_s2 <= r_s1.scale_factor * r_s1.b_im;
			unique case (r_s1.req_type)
				OP_NEG: begin
					s_re_s2 <= -SW'(r_s1.a_re);
					s_im_s2 <= -SW'(r_s1.a_im);
				end
				OP_SUB: begin
					s_re_s2 <= SW'(r_s1.a_re) - SW'(r_s1.b_re);
					s_im_s2 <= SW'(r_s1.a_im) - SW'(r_s1.b_im);
				end
				OP_INC: begin
					s_re_s2 <= SW'(r_s1.a_re) + SW'(1 << FracBits);
					s_im_s2 <= SW'(r_s1.a_im) + SW'(1 << FracBits);
				end
				default: begin
					s_re_s2 <= '0;
					s_im_s2 <= '0;
				end
			endcase
		end
	end

	// Stage 3: sums of products, divisor, pick sign-magnitude or direct value.
	localparam int XW = PW + 2;
	logic signed [XW-1:0] x_re_s3, x_im_s3;
	logic is_div_s3, den0_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			is_div_s3 <= op_s2 == OP_DIV;
			unique case (op_s2)
				OP_MUL: begin
					x_re_s3 <= XW'(p_rr_s2) - XW'(p_ii_s2);
					x_im_s3 <= XW'(p_ir_s2) + XW'(p_ri_s2);
				end
				OP_DIV: begin
					x_re_s3 <= XW'(p_rr_s2) + XW'(p_ii_s2);
					x_im_s3 <= XW'(p_ir_s2) - XW'(p_ri_s2);
				end
				OP_SCALE: begin
					x_re_s3 <= XW'(p_sr_s2);
					x_im_s3 <= XW'(p_si_s2);
				end
				default: begin
					x_re_s3 <= XW'(s_re_s2) <<< FracBits;
					x_im_s3 <= XW'(s_im_s2) <<< FracBits;
				end
			endcase
		end
	end

	// The divisor |b|^2 needs b again; products b*b are taken from stage 1 in parallel.
	logic [PW-1:0] bb_r_s2, bb_i_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			bb_r_s2 <= PW'($signed(r_s1.b_re) * $signed(r_s1.b_re));
			bb_i_s2 <= PW'($signed(r_s1.b_im) * $signed(r_s1.b_im));
		end
	end
	logic [SW-1:0] den_n;
	assign den_n = SW'(bb_r_s2) + SW'(bb_i_s2);
	always_ff @(posedge clk) if (adv) den0_s3 <= den_n == '0;
	logic [SW-1:0] den_r_s3;
	always_ff @(posedge clk) if (adv) den_r_s3 <= den_n;

	// Stage 4: magnitudes and signs.
	logic neg_re_s4, neg_im_s4, div_s4, den0_s4;
	logic [XW-1:0] m_re_s4, m_im_s4;
	logic [SW-1:0] den_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			neg_re_s4 <= x_re_s3[XW-1];
			neg_im_s4 <= x_im_s3[XW-1];
			m_re_s4 <= x_re_s3[XW-1] ? XW'(-x_re_s3) : XW'(x_re_s3);
			m_im_s4 <= x_im_s3[XW-1] ? XW'(-x_im_s3) : XW'(x_im_s3);
			div_s4 <= is_div_s3;
			den0_s4 <= den0_s3;
			den_s4 <= den0_s3 ? SW'(1) : den_r_s3;
		end
	end

	logic [QuoWidth-1:0] q_re, q_im;
	cau_div u_div_re (.clk, .en(adv), .num(SW'(m_re_s4)), .den(den_s4), .quo(q_re));
	cau_div u_div_im (.clk, .en(adv), .num(SW'(m_im_s4)), .den(den_s4), .quo(q_im));

	// Side pipeline carrying the signs, flags and non-divide magnitudes alongside the divider.
	logic neg_re_d [DL+1], neg_im_d [DL+1], div_d [DL+1], den0_d [DL+1];
	logic [XW-1:0] m_re_d [DL+1], m_im_d [DL+1];
	always_comb begin
		neg_re_d[0] = neg_re_s4; neg_im_d[0] = neg_im_s4;
		div_d[0] = div_s4; den0_d[0] = den0_s4;
		m_re_d[0] = m_re_s4; m_im_d[0] = m_im_s4;
	end
	for (genvar k = 0; k < DL; k++) begin : g_d
		always_ff @(posedge clk) begin
			if (adv) begin
				neg_re_d[k+1] <= neg_re_d[k]; neg_im_d[k+1] <= neg_im_d[k];
				div_d[k+1] <= div_d[k]; den0_d[k+1] <= den0_d[k];
				m_re_d[k+1] <= m_re_d[k]; m_im_d[k+1] <= m_im_d[k];
			end
		end
	end

	function automatic logic [W:0] sat_f(input logic neg, input logic [XW-1:0] mag);
		logic [W-1:0] v;
		logic s;
		s = 1'b0;
		if (!neg || mag == '0) begin
			if (mag > XW'((1 << (W-1)) - 1)) begin
				s = 1'b1;
				v = {1'b0, {(W-1){1'b1}}};
			end else begin
				v = mag[W-1:0];
			end
		end else if (mag > XW'(1 << (W-1))) begin
			s = 1'b1;
			v = {1'b1, {(W-1){1'b0}}};
		end else begin
			v = W'(-mag);
		end
		return {s, v};
	endfunction

	// Floor shift for non-divide results: add bias on negative magnitudes.
	function automatic logic [XW-1:0] fl_f(input logic neg, input logic [XW-1:0] m);
		return neg ? (m + XW'((1 << FracBits) - 1)) >> FracBits : m >> FracBits;
	endfunction

	logic [W:0] o_re, o_im;
	logic [XW-1:0] mr, mi;
	always_comb begin
		if (div_d[DL]) begin
			mr = XW'(q_re);
			mi = XW'(q_im);
		end else begin
			mr = fl_f(neg_re_d[DL], m_re_d[DL]);
			mi = fl_f(neg_im_d[DL], m_im_d[DL]);
		end
		o_re = sat_f(neg_re_d[DL], mr);
		o_im = sat_f(neg_im_d[DL], mi);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (div_d[DL] && den0_d[DL]) begin
				rsp.res_re <= '0;
				rsp.res_im <= '0;
				rsp.status <= ST_DIV0;
			end else begin
				rsp.res_re <= o_re[W-1:0];
				rsp.res_im <= o_im[W-1:0];
				rsp.status <= (o_re[W] || o_im[W]) ? ST_SAT : ST_OK;
			end
		end
	end
endmodule

// File: hw/rtl/cau_checker.sv
// Port-level checker for the complex arithmetic unit, bound to the top level.
`include "complex_arithmetic_unit_core_defines.svh"
module cau_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input cau_pkg::rsp_t rsp
);
	import cau_pkg::*;
	`CAU_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response changed while stalled")
	`CAU_ASSERT_IMPL(a_stall_ready, clk, arst_n, rsp_valid && !rsp_ready, !req_ready, "request taken while output stalled")
	`CAU_ASSERT_IMPL(a_status_code, clk, arst_n, rsp_valid, rsp.status != 2'd3, "illegal status code")
	`CAU_ASSERT_IMPL(a_div0_zero, clk, arst_n, rsp_valid && rsp.status == ST_DIV0, rsp.res_re == '0 && rsp.res_im == '0, "divide by zero with nonzero result")
endmodule

bind complex_arithmetic_unit_core cau_checker u_cau_checker (
	.clk, .arst_n, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp
);

// File: dv/tb_top.sv
// Self-checking testbench of the complex arithmetic unit with a built-in arithmetic predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import cau_pkg::*;

	localparam int Latency = 30;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	rsp_t result_q[$];
	int fail_count;
	bit stim_done;
	bit hold_rsp;
	bit quiet_rsp;
	bit hold_started;

	complex_arithmetic_unit_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("simulation failed");
		$finish;
	end

	function automatic longint floor_frac(longint v);
		return v >>> FracBits;
	endfunction

	function automatic longint div_trunc(longint n, longint d);
		longint m;
		longint q;
		m = (n < 0) ? -n : n;
		q = (m * (64'sd1 <<< FracBits)) / d;
		return (n < 0) ? -q : q;
	endfunction

	function automatic logic [DataWidth-1:0] clamp(longint v, ref bit sat);
		longint hi;
		longint lo;
		hi = (64'sd1 <<< (DataWidth - 1)) - 1;
		lo = -(64'sd1 <<< (DataWidth - 1));
		if (v > hi) begin
			sat = 1'b1;
			return hi[DataWidth-1:0];
		end
		if (v < lo) begin
			sat = 1'b1;
			return lo[DataWidth-1:0];
		end
		return v[DataWidth-1:0];
	endfunction

	function automatic rsp_t compute_result(req_t r);
		longint ar, ai, br, bi, sf, re, im, d, one;
		bit sat;
		rsp_t o;
		ar = r.a_re;
		ai = r.a_im;
		br = r.b_re;
		bi = r.b_im;
		sf = r.scale_factor;
		one = 64'sd1 <<< FracBits;
		re = 0;
		im = 0;
		sat = 1'b0;
		o.status = ST_OK;
		case (r.req_type)
			OP_NEG: begin
				re = -ar;
				im = -ai;
			end
			OP_SUB: begin
				re = ar - br;
				im = ai - bi;
			end
			OP_MUL: begin
				re = floor_frac(ar * br - ai * bi);
				im = floor_frac(ai * br + ar * bi);
			end
			OP_DIV: begin
				d = br * br + bi * bi;
				if (d == 0) begin
					o.status = ST_DIV0;
				end else begin
					re = div_trunc(ar * br + ai * bi, d);
					im = div_trunc(ai * br - ar * bi, d);
				end
			end
			OP_INC: begin
				re = ar + one;
				im = ai + one;
			end
			OP_SCALE: begin
				re = floor_frac(sf * br);
				im = floor_frac(sf * bi);
			end
			default: begin
			end
		endcase
		o.res_re = clamp(re, sat);
		o.res_im = clamp(im, sat);
		if (o.status == ST_OK && sat) begin
			o.status = ST_SAT;
		end
		return o;
	endfunction

	typedef struct {
		logic [2:0] op;
		logic [15:0] ar, ai, br, bi, sf;
		bit known;
		logic [15:0] er, ei;
		logic [1:0] es;
	} vec_t;

	vec_t vec_table[] = '{
		'{OP_NEG, 16'h0100, 16'hff00, 0, 0, 0, 1, 16'hff00, 16'h0100, ST_OK},
		'{OP_NEG, 16'h8000, 16'h7fff, 0, 0, 0, 1, 16'h7fff, 16'h8001, ST_SAT},
		'{OP_SUB, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 0, 1, 16'h7fff, 16'h8000, ST_SAT},
		'{OP_SUB, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 0, 1, 0, 0, ST_OK},
		'{OP_MUL, 16'h0100, 16'h0000, 16'h0200, 16'h0300, 0, 1, 16'h0200, 16'h0300, ST_OK},
		'{OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0, 0},
		'{OP_MUL, 16'hffff, 16'h0001, 16'h0001, 16'h0001, 0, 0, 0, 0, 0},
		'{OP_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 0, 0, 0, 0, 0},
		'{OP_DIV, 16'h1234, 16'h5678, 16'h0000, 16'h0000, 0, 1, 0, 0, ST_DIV0},
		'{OP_DIV, 16'h0100, 16'h0100, 16'h0100, 16'h0000, 0, 1, 16'h0100, 16'h0100, ST_OK},
		'{OP_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000, 0, 1, 16'h7fff, 16'h8000, ST_SAT},
		'{OP_DIV, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 0, 0, 0, 0, 0},
		'{OP_DIV, 16'hffff, 16'h0001, 16'h0003, 16'hfffd, 0, 0, 0, 0, 0},
		'{OP_DIV, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 0, 1, 0, 0, ST_OK},
		'{OP_INC, 16'h7fff, 16'h8000, 0, 0, 0, 1, 16'h7fff, 16'h8100, ST_SAT},
		'{OP_INC, 16'h0000, 16'hff00, 0, 0, 0, 1, 16'h0100, 16'h0000, ST_OK},
		'{OP_SCALE, 0, 0, 16'h8000, 16'h7fff, 16'h8000, 0, 0, 0, 0},
		'{OP_SCALE, 0, 0, 16'h0200, 16'hfe00, 16'h0100, 1, 16'h0200, 16'hfe00, ST_OK},
		'{OP_SCALE, 0, 0, 16'hffff, 16'h0001, 16'hffff, 0, 0, 0, 0},
		'{3'd6, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'h5555, 1, 0, 0, ST_OK},
		'{3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1, 0, 0, ST_OK}
	};

	rsp_t fixed_q[$];
	bit known_q[$];

	task automatic send_word(req_t r, bit known, rsp_t fixed);
		req_valid <= 1'b1;
		req <= r;
		result_q.push_back(compute_result(r));
		known_q.push_back(known);
		fixed_q.push_back(fixed);
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	function automatic logic [15:0] rand_field();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(0, 1023)) - 16'd512;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		req_t r;
		rsp_t fx;
		int gap;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		stim_done = 1'b0;
		hold_rsp = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (vec_table[i]) begin
			r.req_type = vec_table[i].op;
			r.a_re = vec_table[i].ar;
			r.a_im = vec_table[i].ai;
			r.b_re = vec_table[i].br;
			r.b_im = vec_table[i].bi;
			r.scale_factor = vec_table[i].sf;
			fx.res_re = vec_table[i].er;
			fx.res_im = vec_table[i].ei;
			fx.status = vec_table[i].es;
			send_word(r, vec_table[i].known, fx);
		end
		for (int n = 0; n < 1800; n++) begin
			if (n == 600) begin
				hold_rsp = 1'b1;
			end
			if (n == 1200) begin
				req_valid <= 1'b0;
				while (result_q.size() != 0) @(negedge clk);
			end
			r.req_type = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(0, 5));
			r.a_re = rand_field();
			r.a_im = rand_field();
			r.b_re = ($urandom_range(0, 15) == 0) ? 16'h0000 : rand_field();
			r.b_im = ($urandom_range(0, 15) == 0) ? 16'h0000 : rand_field();
			r.scale_factor = rand_field();
			send_word(r, 1'b0, fx);
			if ($urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 12);
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		req_valid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		rsp_ready = 1'b0;
		hold_started = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rsp && !hold_started) begin
				hold_started = 1'b1;
				rsp_ready <= 1'b0;
				repeat (200) @(negedge clk);
			end
			if ($urandom_range(0, 99) < 3) begin
				quiet_rsp = ~quiet_rsp;
			end
			rsp_ready <= quiet_rsp ? 1'b1 : ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (result_q.size() == 0) begin
				$display("%t: unexpected word %h", $realtime, rsp);
				fail_count++;
			end else begin
				want = result_q.pop_front();
				if (known_q.pop_front()) begin
					if (fixed_q[0] !== want) begin
						$display("%t: predictor %h disagrees with table %h", $realtime,
							want, fixed_q[0]);
						fail_count++;
					end
				end
				void'(fixed_q.pop_front());
				if (rsp.res_re !== want.res_re) begin
					$display("%t: res_re expected %h actual %h", $realtime,
						want.res_re, rsp.res_re);
					fail_count++;
				end
				if (rsp.res_im !== want.res_im) begin
					$display("%t: res_im expected %h actual %h", $realtime,
						want.res_im, rsp.res_im);
					fail_count++;
				end
				if (rsp.status !== want.status) begin
					$display("%t: status expected %h actual %h", $realtime,
						want.status, rsp.status);
					fail_count++;
				end
			end
		end
	end

	initial begin
		fail_count = 0;
		quiet_rsp = 1'b0;
		wait (stim_done);
		while (result_q.size() != 0) @(posedge clk);
		repeat (Latency + 10) @(posedge clk);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/cau_pkg.sv
hw/rtl/cau_div.sv
hw/rtl/complex_arithmetic_unit_core.sv
hw/rtl/cau_checker.sv
dv/tb_top.sv
